// ===== hdl/hpe_pkg.sv =====
// Shared constants and types for the Horner polynomial bank evaluator.
`default_nettype none
package hpe_pkg;

  localparam int DEF_MAX_COEFFS  = 16;
  localparam int DEF_MAX_COLUMNS = 16;
  localparam int RESULT_LIMIT    = 16;
  localparam int FRAC_BITS       = 16;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  localparam logic REG_POLY_DEGREE  = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  localparam logic [3:0] POLY_DEGREE_RST  = 4'd0;
  localparam logic [4:0] COLUMN_COUNT_RST = 5'd1;

  typedef struct packed {
    logic [3:0] poly_degree;
    logic [4:0] column_count;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/horner_polynomial_bank_eval_unit.sv =====
// Top level: stream ports, configuration registers, store and sequencer.
//
// A load transfer writes one coefficient into the store in the cycle it is
// taken. An evaluate transfer runs every configured column through one
// shared 32x32 multiplier and saturating adder: each column fetches its top
// coefficient, then makes m Horner steps (m = clamped poly_degree), each a
// multiply whose product is registered before the add, and then loads the
// result into the output register.
// The input is taken again once the last result sits in the output
// register; results wait there while the consumer stalls. The store has no
// reset: evaluate only columns whose coefficients 0..m have been loaded.
`default_nettype none
module horner_polynomial_bank_eval_unit #(
  parameter int MAX_COEFFS  = hpe_pkg::DEF_MAX_COEFFS,
  parameter int MAX_COLUMNS = hpe_pkg::DEF_MAX_COLUMNS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [3:0] coeff_column, [7:4] coeff_index, [39:8] coeff_value,
  // [71:40] point_value
  input  wire logic [71:0] s_tdata,
  // [0] action
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [3:0] result_column, [35:4] result_value, [39:36] zero
  output logic      [39:0] m_tdata,
  // [0] overflow
  output logic             m_tuser,
  output logic             m_tlast
);

  localparam int DEPTH  = MAX_COLUMNS * MAX_COEFFS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  hpe_pkg::cfg_t cfg;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;
  logic [3:0]        res_column;
  logic [31:0]       res_value;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poly_degree  <= hpe_pkg::POLY_DEGREE_RST;
      cfg.column_count <= hpe_pkg::COLUMN_COUNT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        hpe_pkg::REG_POLY_DEGREE:  cfg.poly_degree  <= pwdata[3:0];
        hpe_pkg::REG_COLUMN_COUNT: cfg.column_count <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      hpe_pkg::REG_POLY_DEGREE:  prdata = {28'd0, cfg.poly_degree};
      hpe_pkg::REG_COLUMN_COUNT: prdata = {27'd0, cfg.column_count};
      default:                   prdata = 32'd0;
    endcase
  end

  hpe_coef_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hpe_seq #(
    .MAX_COEFFS  (MAX_COEFFS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .ADDR_W      (ADDR_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_action    (s_tuser),
    .in_column    (s_tdata[3:0]),
    .in_index     (s_tdata[7:4]),
    .in_coeff     (s_tdata[39:8]),
    .in_point     (s_tdata[71:40]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_column   (res_column),
    .out_value    (res_value),
    .out_overflow (m_tuser),
    .out_last     (m_tlast),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  assign m_tdata = {4'd0, res_value, res_column};

endmodule
`default_nettype wire

// ===== hdl/hpe_coef_ram.sv =====
// Coefficient store: one write port, one registered read port.
`default_nettype none
module hpe_coef_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [31:0]       wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [31:0]       rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hpe_seq.sv =====
// Horner sequencer: walks the store per column with one shared multiply-add.
`default_nettype none
module hpe_seq #(
  parameter int MAX_COEFFS  = hpe_pkg::DEF_MAX_COEFFS,
  parameter int MAX_COLUMNS = hpe_pkg::DEF_MAX_COLUMNS,
  parameter int ADDR_W      = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hpe_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_action,
  input  wire logic [3:0]        in_column,
  input  wire logic [3:0]        in_index,
  input  wire logic [31:0]       in_coeff,
  input  wire logic [31:0]       in_point,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [3:0]        out_column,
  output logic      [31:0]       out_value,
  output logic                   out_overflow,
  output logic                   out_last,
  output logic                   ram_we,
  output logic      [ADDR_W-1:0] ram_waddr,
  output logic      [31:0]       ram_wdata,
  output logic                   ram_re,
  output logic      [ADDR_W-1:0] ram_raddr,
  input  wire logic [31:0]       ram_rdata
);

  localparam int COL_LIM = (MAX_COLUMNS < hpe_pkg::RESULT_LIMIT) ?
                           MAX_COLUMNS : hpe_pkg::RESULT_LIMIT;
  localparam int J_W = (COL_LIM > 1) ? $clog2(COL_LIM) : 1;
  localparam int N_W = $clog2(COL_LIM + 1);
  localparam int K_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_MUL,
    S_ADD,
    S_OUT
  } state_t;

  state_t state;

  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [63:0] prod;
  logic               ovf;
  logic [J_W-1:0]     j;
  logic [K_W-1:0]     k;
  logic [K_W-1:0]     deg;
  logic [N_W-1:0]     ncols;

  logic [K_W-1:0]     deg_eff;
  logic [N_W-1:0]     ncols_eff;
  logic               accept;
  logic               last_col;
  logic               out_free;
  logic               out_load;
  logic signed [48:0] sum;
  logic signed [31:0] sat_value;
  logic               sat_flag;

  always_comb begin
    deg_eff = (32'(cfg.poly_degree) > MAX_COEFFS - 1) ? K_W'(MAX_COEFFS - 1)
                                                       : K_W'(cfg.poly_degree);
    ncols_eff = (32'(cfg.column_count) > COL_LIM) ? N_W'(COL_LIM)
                                                   : N_W'(cfg.column_count);
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_col = (8'(j) + 8'd1) == 8'(ncols);
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == S_OUT) && out_free;

  // coefficient load path
  always_comb begin
    ram_we    = accept && (in_action == hpe_pkg::ACT_LOAD) &&
                (32'(in_column) < MAX_COLUMNS) && (32'(in_index) < MAX_COEFFS);
    ram_waddr = ADDR_W'(32'(in_column) * MAX_COEFFS + 32'(in_index));
    ram_wdata = in_coeff;
  end

  // read issue, ahead of the state that uses the data
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(32'(j) * MAX_COEFFS + 32'(k) - 1);
    case (state)
      S_IDLE: begin
        ram_re    = accept && (in_action == hpe_pkg::ACT_EVAL) && (ncols_eff != '0);
        ram_raddr = ADDR_W'(32'(deg_eff));
      end
      S_TOP, S_ADD: begin
        ram_re = (k != '0);
      end
      S_OUT: begin
        ram_re    = out_free && !last_col;
        ram_raddr = ADDR_W'((32'(j) + 1) * MAX_COEFFS + 32'(deg));
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // c_k + (x*y >>> 16), saturated to 32 bits
  always_comb begin
    sum = 49'(signed'(ram_rdata)) + signed'({prod[63], prod[63:hpe_pkg::FRAC_BITS]});
    sat_flag  = 1'b0;
    sat_value = sum[31:0];
    if (sum > 49'sd2147483647) begin
      sat_flag  = 1'b1;
      sat_value = 32'sh7fffffff;
    end else if (sum < -49'sd2147483648) begin
      sat_flag  = 1'b1;
      sat_value = 32'sh80000000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (in_action == hpe_pkg::ACT_EVAL)) begin
            x     <= in_point;
            j     <= '0;
            k     <= deg_eff;
            deg   <= deg_eff;
            ncols <= ncols_eff;
            if (ncols_eff != '0) begin
              state <= S_TOP;
            end
          end
        end
        S_TOP: begin
          y   <= ram_rdata;
          ovf <= 1'b0;
          if (k == '0) begin
            state <= S_OUT;
          end else begin
            k     <= k - 1'b1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= x * y;
          state <= S_ADD;
        end
        S_ADD: begin
          y   <= sat_value;
          ovf <= ovf | sat_flag;
          if (k == '0) begin
            state <= S_OUT;
          end else begin
            k     <= k - 1'b1;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_column   <= 4'(j);
            out_value    <= y;
            out_overflow <= ovf;
            out_last     <= last_col;
            if (last_col) begin
              state <= S_IDLE;
            end else begin
              j     <= j + 1'b1;
              k     <= deg;
              state <= S_TOP;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the Horner polynomial bank evaluator.
module testbench;

  localparam int NCOEF = hpe_pkg::DEF_MAX_COEFFS;
  localparam int NCOL = hpe_pkg::DEF_MAX_COLUMNS;
  localparam int LOW_DEG = 2;
  localparam int SETTLE = 600;
  localparam int LIMIT = 1000000;
  localparam int IDLE_PCT = 24;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct {
    logic [3:0]  column;
    logic [31:0] value;
    logic        ovf;
    logic        last;
  } poly_result_t;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // [3:0] coeff_column, [7:4] coeff_index, [39:8] coeff_value, [71:40] point_value
  logic [71:0] s_tdata = '0;
  // [0] action
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // [3:0] result_column, [35:4] result_value, [39:36] zero
  logic [39:0] m_tdata;
  // [0] overflow
  logic m_tuser;
  logic m_tlast;

  logic signed [31:0] coeff_bank [NCOL][NCOEF];
  logic [3:0] degree_reg = hpe_pkg::POLY_DEGREE_RST;
  logic [4:0] columns_reg = hpe_pkg::COLUMN_COUNT_RST;
  poly_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;
  bit steady = 1'b0;

  horner_polynomial_bank_eval_unit DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, or a counted hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Horner evaluation of every configured column at point x
  function automatic void evaluate_point(input logic signed [31:0] x);
    int ncols;
    int deg;
    longint acc;
    longint sum;
    poly_result_t r;
    ncols = (columns_reg > NCOL) ? NCOL : columns_reg;
    if (ncols > hpe_pkg::RESULT_LIMIT) ncols = hpe_pkg::RESULT_LIMIT;
    deg = (degree_reg > NCOEF - 1) ? NCOEF - 1 : degree_reg;
    for (int j = 0; j < ncols; j++) begin
      acc = coeff_bank[j][deg];
      r.ovf = 1'b0;
      for (int k = deg - 1; k >= 0; k--) begin
        sum = longint'(coeff_bank[j][k]) + ((longint'(x) * acc) >>> hpe_pkg::FRAC_BITS);
        if (sum > SAT_HI) begin
          sum = SAT_HI;
          r.ovf = 1'b1;
        end else if (sum < SAT_LO) begin
          sum = SAT_LO;
          r.ovf = 1'b1;
        end
        acc = sum;
      end
      r.column = 4'(j);
      r.value = acc[31:0];
      r.last = (j == ncols - 1);
      pending_results.push_back(r);
    end
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    poly_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual column %0d value %h",
                 $time, m_tdata[3:0], m_tdata[35:4]);
      end else begin
        want = pending_results.pop_front();
        check_field("result_column", 32'(want.column), 32'(m_tdata[3:0]));
        check_field("result_value", want.value, m_tdata[35:4]);
        check_field("overflow", 32'(want.ovf), 32'(m_tuser));
        check_field("last", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(19))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'h0;
      default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_point();
    case ($urandom_range(11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'h0001_0000;
      4: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  task automatic send_item(input logic act, input logic [3:0] col, input logic [3:0] idx,
                           input logic [31:0] coeff, input logic [31:0] point);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {point, coeff, idx, col};
    do @(posedge clk); while (!s_tready);
    if (act == hpe_pkg::ACT_LOAD)
      coeff_bank[col][idx] = coeff;
    else
      evaluate_point(point);
  endtask

  task automatic send_eval(input logic [31:0] point);
    send_item(hpe_pkg::ACT_EVAL, 4'($urandom()), 4'($urandom()), $urandom(), point);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic sel, input logic [31:0] wdata);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {sel, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    want = (sel == hpe_pkg::REG_POLY_DEGREE) ? 32'(degree_reg) : 32'(columns_reg);
    if (wr) begin
      if (sel == hpe_pkg::REG_POLY_DEGREE)
        degree_reg = wdata[3:0];
      else
        columns_reg = wdata[4:0];
    end else begin
      check_field(sel == hpe_pkg::REG_POLY_DEGREE ? "poly_degree read" : "column_count read",
                  want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // settle, then write both registers (unused upper bits random) and read them back
  task automatic configure(input int deg, input int cols);
    drain();
    repeat (SETTLE) @(posedge clk);
    reg_access(1'b1, hpe_pkg::REG_COLUMN_COUNT, ($urandom() & ~32'h1F) | 32'(cols));
    reg_access(1'b1, hpe_pkg::REG_POLY_DEGREE, ($urandom() & ~32'hF) | 32'(deg));
    reg_access(1'b0, hpe_pkg::REG_POLY_DEGREE, '0);
    reg_access(1'b0, hpe_pkg::REG_COLUMN_COUNT, '0);
  endtask

  task automatic test_register_reset();
    reg_access(1'b0, hpe_pkg::REG_POLY_DEGREE, '0);
    reg_access(1'b0, hpe_pkg::REG_COLUMN_COUNT, '0);
  endtask

  // every column up to LOW_DEG, column 0 at all degrees; evaluations stay inside this
  task automatic test_load_bank();
    for (int c = 0; c < NCOL; c++)
      for (int k = 0; k <= LOW_DEG; k++)
        send_item(hpe_pkg::ACT_LOAD, 4'(c), 4'(k), pick_coeff(), $urandom());
    for (int k = LOW_DEG + 1; k < NCOEF; k++)
      send_item(hpe_pkg::ACT_LOAD, 4'd0, 4'(k), pick_coeff(), $urandom());
  endtask

  task automatic test_directed();
    // degree zero at reset settings
    send_eval(32'h0);
    send_item(hpe_pkg::ACT_LOAD, 4'd0, 4'd0, 32'h7FFF_FFFF, $urandom());
    send_eval(32'h7FFF_FFFF);
    send_item(hpe_pkg::ACT_LOAD, 4'd0, 4'd0, 32'h8000_0000, $urandom());
    send_eval(32'h8000_0000);
    // full degree, one column
    configure(15, 1);
    send_eval(32'h0);
    send_eval(32'h0001_0000);
    send_eval(32'h7FFF_FFFF);
    send_eval(32'h8000_0000);
    send_eval(32'hFFFF_FFFF);
    send_item(hpe_pkg::ACT_LOAD, 4'd0, 4'd15, 32'h7FFF_FFFF, $urandom());
    send_item(hpe_pkg::ACT_LOAD, 4'd0, 4'd0, 32'h8000_0000, $urandom());
    send_eval(32'h7FFF_FFFF);
    // zero columns: no result
    configure(3, 0);
    send_eval(pick_point());
    // column count above the bank size: clamped
    configure(LOW_DEG, 31);
    send_eval(pick_point());
  endtask

  task automatic test_random();
    int deg;
    int cols;
    for (int phase = 0; phase < 8; phase++) begin
      if ($urandom_range(3) == 0) begin
        deg = $urandom_range(NCOEF - 1);
        cols = 1;
      end else begin
        deg = $urandom_range(LOW_DEG);
        cols = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 4);
      end
      configure(deg, cols);
      steady = (phase == 3);
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(99) < 35)
          send_item(hpe_pkg::ACT_LOAD, 4'($urandom()), 4'($urandom()), pick_coeff(),
                    $urandom());
        else
          send_eval(pick_point());
      end
      steady = 1'b0;
    end
  endtask

  // output held off long enough that the input stalls, then a full drain
  task automatic test_backpressure();
    configure(LOW_DEG, 16);
    hold_cycles = 2000;
    for (int i = 0; i < 5; i++) send_eval(pick_point());
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_load_bank();
    test_directed();
    test_random();
    test_backpressure();
    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hpe_pkg.sv
hdl/hpe_coef_ram.sv
hdl/hpe_seq.sv
hdl/horner_polynomial_bank_eval_unit.sv
tb/testbench.sv
